FILE: sv/mpid_pkg.sv
// Shared types, widths, register indexes and a helper function for the
// multichannel PID controller. No dependencies.
`default_nettype none

package mpid_pkg;

  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int CH_W    = 3;
  localparam int GAIN_W  = 24;
  localparam int LIM_W   = 15;
  localparam int GATE_W  = 16;
  localparam int DRIVE_W = 16;
  localparam int ERR_W   = SAMPLE_BITS + 1;
  localparam int ACC_W   = LIM_W + 1 + FRAC_BITS;
  localparam int PROD_W  = GAIN_W + ERR_W + 3;
  localparam int SUM_W   = GAIN_W + ERR_W + 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int IN_TDATA_W  = ((CH_W + 2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CH_W + DRIVE_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND       = 3'd7;

  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  max_output;
    logic [GATE_W-1:0] error_limit;
    logic [GATE_W-1:0] deadband;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] integral_acc;
    logic signed [ACC_W-1:0] running_out;
    logic signed [ERR_W-1:0] last_error;
    logic signed [ERR_W-1:0] prev_error;
  } chan_state_t;

  function automatic logic signed [SUM_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W - LIM_W - FRAC_BITS){1'b0}}, lim, {FRAC_BITS{1'b0}}};
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/multichannel_pid_controller.sv
// The block takes one word per clock while the output is not stalled: a channel, a
// measured speed and a setpoint, and returns one word per input with the drive for
// that channel. A word passes the input register, then one
// pass of arithmetic (three gain multipliers, adders and two clamps) that also reads and
// writes the channel's state, into the result register; back-to-back words on the same
// channel are handled because the state write lands at the same edge the result is
// registered. Per-channel state lives in flip-flops cleared by reset, so no clearing
// pass is needed. The configuration port is always ready; write it only while idle.
// Depends on mpid_pkg, mpid_cfg_regs, mpid_state and mpid_datapath.
`default_nettype none

module multichannel_pid_controller
  import mpid_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: channel[2:0], measured[18:3], setpoint[34:19], zero fill above.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // out_tdata: channel_out[2:0], drive[18:3], zero fill above.
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: gated[0].
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                       cfg;
  chan_state_t                st_rd;
  chan_state_t                st_wr;
  logic                       st_upd;
  logic signed [DRIVE_W-1:0]  dp_drive;
  logic                       dp_gated;
  logic                       move;

  logic                       s1_v_r;
  logic [CH_W-1:0]            s1_ch_r;
  logic signed [SAMPLE_BITS-1:0] s1_meas_r;
  logic signed [SAMPLE_BITS-1:0] s1_set_r;

  logic                       o_v_r;
  logic [CH_W-1:0]            o_ch_r;
  logic signed [DRIVE_W-1:0]  o_drive_r;
  logic                       o_gated_r;

  assign cfg_ready = 1'b1;

  mpid_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign move      = s1_v_r && (!o_v_r || out_tready);
  assign in_tready = !s1_v_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r   <= in_tdata[CH_W-1:0];
      s1_meas_r <= in_tdata[CH_W+SAMPLE_BITS-1:CH_W];
      s1_set_r  <= in_tdata[CH_W+2*SAMPLE_BITS-1:CH_W+SAMPLE_BITS];
    end
  end

  mpid_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_ch    (s1_ch_r),
    .rd_state (st_rd),
    .wr_en    (move && st_upd),
    .wr_ch    (s1_ch_r),
    .wr_state (st_wr)
  );

  mpid_datapath u_dp (
    .cfg      (cfg),
    .channel  (s1_ch_r),
    .measured (s1_meas_r),
    .setpoint (s1_set_r),
    .st_in    (st_rd),
    .st_out   (st_wr),
    .st_upd   (st_upd),
    .drive    (dp_drive),
    .gated    (dp_gated)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (!o_v_r || out_tready) begin
      o_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      o_ch_r    <= s1_ch_r;
      o_drive_r <= dp_drive;
      o_gated_r <= dp_gated;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_gated_r;
  assign out_tdata  = {{(OUT_TDATA_W - CH_W - DRIVE_W){1'b0}}, o_drive_r, o_ch_r};

  a_gated_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_gated_r) |-> (o_drive_r == '0))
    else $error("gated result carries a nonzero drive");

  a_drive_sym : assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> (o_drive_r != {1'b1, {(DRIVE_W-1){1'b0}}}))
    else $error("drive left the symmetric clamp range");

  a_bad_channel : assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && (o_ch_r >= CH_W'(CHANNELS))) |-> (!o_gated_r && (o_drive_r == '0)))
    else $error("out-of-range channel produced a drive or gate");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !move) |=> (s1_v_r && $stable(s1_ch_r)))
    else $error("stalled input stage lost its word");

  a_state_write : assert property (@(posedge clk) disable iff (!rst_n)
    (move && st_upd) |-> (s1_ch_r < CH_W'(CHANNELS)))
    else $error("state write to a channel that does not exist");

endmodule

`default_nettype wire

FILE: sv/mpid_cfg_regs.sv
// Configuration register file of the multichannel PID controller.
// Depends on mpid_pkg for register indexes, widths and cfg_t.
`default_nettype none

module mpid_cfg_regs
  import mpid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MODE:           cfg_nxt.mode           = wr_data[0];
        REG_GAIN_P:         cfg_nxt.gain_p         = wr_data[GAIN_W-1:0];
        REG_GAIN_I:         cfg_nxt.gain_i         = wr_data[GAIN_W-1:0];
        REG_GAIN_D:         cfg_nxt.gain_d         = wr_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = wr_data[LIM_W-1:0];
        REG_MAX_OUTPUT:     cfg_nxt.max_output     = wr_data[LIM_W-1:0];
        REG_ERROR_LIMIT:    cfg_nxt.error_limit    = wr_data[GATE_W-1:0];
        REG_DEADBAND:       cfg_nxt.deadband       = wr_data[GATE_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_POSITIONAL;
      cfg_r.gain_p         <= GAIN_W'(150733);
      cfg_r.gain_i         <= GAIN_W'(655);
      cfg_r.gain_d         <= '0;
      cfg_r.integral_limit <= LIM_W'(5000);
      cfg_r.max_output     <= LIM_W'(20000);
      cfg_r.error_limit    <= '0;
      cfg_r.deadband       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/mpid_state.sv
// Per-channel controller state held in flip-flops, cleared by reset.
// Depends on mpid_pkg for chan_state_t and the channel count.
`default_nettype none

module mpid_state
  import mpid_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [CH_W-1:0] rd_ch,
  output chan_state_t          rd_state,
  input  wire logic            wr_en,
  input  wire logic [CH_W-1:0] wr_ch,
  input  wire chan_state_t     wr_state
);

  chan_state_t st_r [CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= '0;
      end
    end else if (wr_en) begin
      st_r[wr_ch] <= wr_state;
    end
  end

  always_comb begin
    rd_state = '0;
    if (rd_ch < CH_W'(CHANNELS)) begin
      rd_state = st_r[rd_ch];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mpid_datapath.sv
// One-pass PID arithmetic: error, gating, three gain products, clamps and
// truncation of the drive. Depends on mpid_pkg for types and clamp_sym.
`default_nettype none

module mpid_datapath
  import mpid_pkg::*;
(
  input  wire cfg_t                      cfg,
  input  wire logic [CH_W-1:0]           channel,
  input  wire logic signed [SAMPLE_BITS-1:0] measured,
  input  wire logic signed [SAMPLE_BITS-1:0] setpoint,
  input  wire chan_state_t               st_in,
  output chan_state_t                    st_out,
  output logic                           st_upd,
  output logic signed [DRIVE_W-1:0]      drive,
  output logic                           gated
);

  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          mag;
  logic [SUM_W-1:0]          mag_x;
  logic [SUM_W-1:0]          el_x;
  logic [SUM_W-1:0]          db_x;
  logic                      in_range;
  logic                      gate;
  logic signed [ERR_W:0]     d1;
  logic signed [ERR_W+1:0]   d2;
  logic signed [ERR_W+1:0]   p_op;
  logic signed [ERR_W+1:0]   i_op;
  logic signed [ERR_W+1:0]   d_op;
  logic signed [PROD_W-1:0]  prod_p;
  logic signed [PROD_W-1:0]  prod_i;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [SUM_W-1:0]   pp;
  logic signed [SUM_W-1:0]   pi;
  logic signed [SUM_W-1:0]   pd;
  logic signed [SUM_W-1:0]   iacc;
  logic signed [SUM_W-1:0]   run;
  logic signed [SUM_W-1:0]   isum;
  logic signed [SUM_W-1:0]   inew;
  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   onew;
  logic signed [ACC_W-1:0]   q;
  logic signed [DRIVE_W-1:0] q_hi;

  assign err = $signed({setpoint[SAMPLE_BITS-1], setpoint})
             - $signed({measured[SAMPLE_BITS-1], measured});
  assign mag = err[ERR_W-1] ? (~err + ERR_W'(1)) : err;

  assign mag_x = {{(SUM_W - ERR_W){1'b0}}, mag};
  assign el_x  = {{(SUM_W - GATE_W){1'b0}}, cfg.error_limit};
  assign db_x  = {{(SUM_W - GATE_W){1'b0}}, cfg.deadband};
  assign gate  = ((cfg.error_limit != '0) && (mag_x > el_x))
              || ((cfg.deadband != '0) && (mag_x < db_x));
  assign in_range = channel < CH_W'(CHANNELS);

  assign d1 = $signed({err[ERR_W-1], err})
            - $signed({st_in.last_error[ERR_W-1], st_in.last_error});
  assign d2 = $signed({d1[ERR_W], d1})
            - $signed({{2{st_in.last_error[ERR_W-1]}}, st_in.last_error})
            + $signed({{2{st_in.prev_error[ERR_W-1]}}, st_in.prev_error});

  always_comb begin
    i_op = $signed({{2{err[ERR_W-1]}}, err});
    if (cfg.mode == MODE_INCREMENTAL) begin
      p_op = $signed({d1[ERR_W], d1});
      d_op = d2;
    end else begin
      p_op = $signed({{2{err[ERR_W-1]}}, err});
      d_op = $signed({d1[ERR_W], d1});
    end
  end

  assign prod_p = $signed({1'b0, cfg.gain_p}) * p_op;
  assign prod_i = $signed({1'b0, cfg.gain_i}) * i_op;
  assign prod_d = $signed({1'b0, cfg.gain_d}) * d_op;

  assign pp   = SUM_W'(prod_p);
  assign pi   = SUM_W'(prod_i);
  assign pd   = SUM_W'(prod_d);
  assign iacc = SUM_W'(st_in.integral_acc);
  assign run  = SUM_W'(st_in.running_out);

  always_comb begin
    if (cfg.mode == MODE_INCREMENTAL) begin
      isum = pi;
    end else begin
      isum = pi + iacc;
    end
    inew = clamp_sym(isum, cfg.integral_limit);
    if (cfg.mode == MODE_INCREMENTAL) begin
      total = run + pp + inew + pd;
    end else begin
      total = pp + inew + pd;
    end
    onew = clamp_sym(total, cfg.max_output);
  end

  assign q    = ACC_W'(onew);
  assign q_hi = q[ACC_W-1:FRAC_BITS];

  always_comb begin
    st_out.integral_acc = ACC_W'(inew);
    st_out.running_out  = (cfg.mode == MODE_INCREMENTAL) ? q : st_in.running_out;
    st_out.last_error   = err;
    st_out.prev_error   = st_in.last_error;
    st_upd = in_range && !gate;
    gated  = in_range && gate;
    if (st_upd) begin
      drive = (q[ACC_W-1] && (q[FRAC_BITS-1:0] != '0)) ? (q_hi + DRIVE_W'(1)) : q_hi;
    end else begin
      drive = '0;
    end
  end

endmodule

`default_nettype wire
